// File: design/cac_pkg.sv
package cac_pkg;

   // tolerance register
   localparam int TOL_W = 25;
   localparam logic [TOL_W-1:0] TOL_RESET = 25'd17;

   // result status
   localparam int STATUS_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND      = 3'd0,
      ST_CONSTANT   = 3'd1,
      ST_LINEAR     = 3'd2,
      ST_NONCONVEX  = 3'd3,
      ST_NO_ROOT    = 3'd4,
      ST_SADDLE     = 3'd5,
      ST_UNEXPECTED = 3'd6
   } status_type;

   // path control that travels with each transaction
   typedef struct packed {
      logic       quad;
      logic       cubic;
      status_type status;
   } ctl_type;

endpackage

// File: design/cac_req_if.sv
interface cac_req_if #(parameter int DATA_WIDTH = 48);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] origin;
   logic signed [DATA_WIDTH-1:0] lin_coef;
   logic signed [DATA_WIDTH-1:0] quad_coef;
   logic signed [DATA_WIDTH-1:0] cube_coef;

   modport source (output valid, output origin, output lin_coef, output quad_coef,
                   output cube_coef, input ready);
   modport sink (input valid, input origin, input lin_coef, input quad_coef,
                 input cube_coef, output ready);
endinterface

// File: design/cac_rsp_if.sv
interface cac_rsp_if #(parameter int DATA_WIDTH = 48);
   import cac_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] argmin;
   logic [STATUS_W-1:0]          status;

   modport source (output valid, output argmin, output status, input ready);
   modport sink (input valid, input argmin, input status, output ready);
endinterface

// File: design/cubic_argmin_classifier.sv
// Local minimiser of a cubic a + b*t + c*t^2 + d*t^3 around origin x0, all values
// signed fixed point with FRAC_BITS fraction bits in DATA_WIDTH bits. A transaction
// can be accepted in every cycle while the skid stage is empty; each result goes through
// the square-root pipeline (one root bit per stage, DATA_WIDTH + 1 stages) and the
// divider pipeline (one quotient bit per stage, DATA_WIDTH + FRAC_BITS + 1 stages). An
// output register with a skid stage decouples the result side; while the skid is
// occupied the whole pipeline holds. The tolerance register should be written only
// when the block is idle.
module cubic_argmin_classifier #(
   parameter int DATA_WIDTH = 48,
   parameter int FRAC_BITS  = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   cac_req_if.sink                   req_if,
   cac_rsp_if.source                 rsp_if,
   input  logic                      csr_wr_en,
   input  logic [cac_pkg::TOL_W-1:0] csr_wr_data
);
   import cac_pkg::*;

   localparam int W        = DATA_WIDTH;
   localparam int F        = FRAC_BITS;
   localparam int MW       = 2 * W + 2;
   localparam int ROOT_W   = MW / 2;
   localparam int NUM_W    = W + 1 + F;
   localparam int DEN_W    = W + 1;
   localparam int SUM_W    = NUM_W + 2;
   localparam int TT_W     = 2 * TOL_W;
   localparam int CMP_W    = (W > TOL_W) ? W : TOL_W;
   localparam int CW_A     = (2 * W + 4 > TOL_W + F) ? 2 * W + 4 : TOL_W + F;
   localparam int CW       = (CW_A > TT_W) ? CW_A : TT_W;
   localparam int CTL_W    = $bits(ctl_type);
   localparam int SQ_SIDE_W = CTL_W + 4 * W;
   localparam int DV_SIDE_W = STATUS_W + W + 1;

   logic en;

   // tolerance register and its square
   logic [TOL_W-1:0] tol_ff;
   logic [TT_W-1:0]  tt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      tt_ff <= TT_W'(tol_ff) * TT_W'(tol_ff);
   end

   // input capture
   logic                s0_vld_ff;
   logic signed [W-1:0] s0_x0_ff, s0_b_ff, s0_c_ff, s0_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x0_ff <= req_if.origin;
         s0_b_ff  <= req_if.lin_coef;
         s0_c_ff  <= req_if.quad_coef;
         s0_d_ff  <= req_if.cube_coef;
      end
   end

   // near-zero tests and quadratic classification
   logic [W-1:0] s0_mag_b, s0_mag_c, s0_mag_d;
   logic         b_small, c_small, d_small, c_le0, d_zero;
   ctl_type      ctl1_in;

   always_comb begin
      s0_mag_b = s0_b_ff[W-1] ? W'(-s0_b_ff) : W'(s0_b_ff);
      s0_mag_c = s0_c_ff[W-1] ? W'(-s0_c_ff) : W'(s0_c_ff);
      s0_mag_d = s0_d_ff[W-1] ? W'(-s0_d_ff) : W'(s0_d_ff);
      b_small  = CMP_W'(s0_mag_b) < CMP_W'(tol_ff);
      c_small  = CMP_W'(s0_mag_c) < CMP_W'(tol_ff);
      d_small  = CMP_W'(s0_mag_d) < CMP_W'(tol_ff);
      c_le0    = s0_c_ff[W-1] || (s0_c_ff == '0);
      d_zero   = s0_d_ff == '0;
      ctl1_in.quad   = 1'b0;
      ctl1_in.cubic  = 1'b0;
      ctl1_in.status = ST_FOUND;
      if (d_small) begin
         if (c_small) begin
            ctl1_in.status = b_small ? ST_CONSTANT : ST_LINEAR;
         end else if (c_le0) begin
            ctl1_in.status = ST_NONCONVEX;
         end else begin
            ctl1_in.quad = 1'b1;
         end
      end else if (d_zero) begin
         ctl1_in.status = ST_UNEXPECTED;
      end else begin
         ctl1_in.cubic = 1'b1;
      end
   end

   // c*c and d*b, two stages each
   logic signed [2*W-1:0] cc, db;

   cac_mul #(.W(W)) u_mul_cc (
      .clock (clock),
      .en    (en),
      .a     (s0_c_ff),
      .b     (s0_c_ff),
      .p     (cc)
   );

   cac_mul #(.W(W)) u_mul_db (
      .clock (clock),
      .en    (en),
      .a     (s0_d_ff),
      .b     (s0_b_ff),
      .p     (db)
   );

   // side data alongside the multipliers
   logic                s1_vld_ff, s2_vld_ff;
   ctl_type             s1_ctl_ff, s2_ctl_ff;
   logic signed [W-1:0] s1_x0_ff, s1_b_ff, s1_c_ff, s1_d_ff;
   logic signed [W-1:0] s2_x0_ff, s2_b_ff, s2_c_ff, s2_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ctl_ff <= ctl1_in;
         s1_x0_ff  <= s0_x0_ff;
         s1_b_ff   <= s0_b_ff;
         s1_c_ff   <= s0_c_ff;
         s1_d_ff   <= s0_d_ff;
         s2_ctl_ff <= s1_ctl_ff;
         s2_x0_ff  <= s1_x0_ff;
         s2_b_ff   <= s1_b_ff;
         s2_c_ff   <= s1_c_ff;
         s2_d_ff   <= s1_d_ff;
      end
   end

   // m = c*c - 3*d*b
   logic signed [MW-1:0] cc_ext, db_ext, m_in;
   logic                 s3_vld_ff;
   ctl_type              s3_ctl_ff;
   logic signed [MW-1:0] s3_m_ff;
   logic signed [W-1:0]  s3_x0_ff, s3_b_ff, s3_c_ff, s3_d_ff;

   always_comb begin
      cc_ext = MW'(cc);
      db_ext = MW'(db);
      m_in   = cc_ext - (db_ext <<< 1) - db_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ctl_ff <= s2_ctl_ff;
         s3_m_ff   <= m_in;
         s3_x0_ff  <= s2_x0_ff;
         s3_b_ff   <= s2_b_ff;
         s3_c_ff   <= s2_c_ff;
         s3_d_ff   <= s2_d_ff;
      end
   end

   // discriminant classification
   logic            m_neg, m_zero, lt_lim, lt_tt;
   logic [MW-1:0]   abs_m;
   logic [CW-1:0]   four_abs, lim;
   ctl_type         ctl4_in;
   logic [MW-1:0]   opnd_in;

   always_comb begin
      m_neg    = s3_m_ff[MW-1];
      m_zero   = s3_m_ff == '0;
      abs_m    = m_neg ? MW'(-s3_m_ff) : MW'(s3_m_ff);
      four_abs = CW'(abs_m) << 2;
      lim      = CW'(tol_ff) << F;
      lt_lim   = four_abs < lim;
      lt_tt    = four_abs < CW'(tt_ff);
      ctl4_in  = s3_ctl_ff;
      if (s3_ctl_ff.cubic) begin
         if (lt_lim) begin
            ctl4_in.status = ST_SADDLE;
         end else if (m_neg) begin
            ctl4_in.status = ST_NO_ROOT;
         end else if (lt_tt) begin
            ctl4_in.status = ST_SADDLE;
         end else if (m_zero) begin
            ctl4_in.status = ST_UNEXPECTED;
         end else begin
            ctl4_in.status = ST_FOUND;
         end
      end
      opnd_in = m_neg ? '0 : MW'(s3_m_ff);
   end

   logic                s4_vld_ff;
   ctl_type             s4_ctl_ff;
   logic [MW-1:0]       s4_opnd_ff;
   logic signed [W-1:0] s4_x0_ff, s4_b_ff, s4_c_ff, s4_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ctl_ff  <= ctl4_in;
         s4_opnd_ff <= opnd_in;
         s4_x0_ff   <= s3_x0_ff;
         s4_b_ff    <= s3_b_ff;
         s4_c_ff    <= s3_c_ff;
         s4_d_ff    <= s3_d_ff;
      end
   end

   // floor square root of m
   logic                 sq_vld;
   logic [ROOT_W-1:0]    sq_root;
   logic [SQ_SIDE_W-1:0] sq_side;

   cac_sqrt #(.IN_W(MW), .SIDE_W(SQ_SIDE_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s4_vld_ff),
      .in_opnd  (s4_opnd_ff),
      .in_side  ({s4_ctl_ff, s4_x0_ff, s4_b_ff, s4_c_ff, s4_d_ff}),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // numerator and denominator in sign-magnitude form
   ctl_type             sq_ctl;
   logic signed [W-1:0] sq_x0, sq_b, sq_c, sq_d;
   logic [W-1:0]        sq_mag_b, sq_mag_c, sq_mag_d;
   logic signed [W+1:0] diff;
   logic [W:0]          nmag, dmag;
   logic                nneg, dneg;

   always_comb begin
      sq_ctl   = ctl_type'(sq_side[SQ_SIDE_W-1 -: CTL_W]);
      sq_x0    = $signed(sq_side[4*W-1 -: W]);
      sq_b     = $signed(sq_side[3*W-1 -: W]);
      sq_c     = $signed(sq_side[2*W-1 -: W]);
      sq_d     = $signed(sq_side[W-1:0]);
      sq_mag_b = sq_b[W-1] ? W'(-sq_b) : W'(sq_b);
      sq_mag_c = sq_c[W-1] ? W'(-sq_c) : W'(sq_c);
      sq_mag_d = sq_d[W-1] ? W'(-sq_d) : W'(sq_d);
      diff     = $signed({1'b0, sq_root}) - (W+2)'(sq_c);
      if (sq_ctl.quad) begin
         nmag = (W+1)'(sq_mag_b);
         nneg = !sq_b[W-1] && (sq_b != '0);
         dmag = {sq_mag_c, 1'b0};
         dneg = 1'b0;
      end else begin
         nmag = diff[W+1] ? (W+1)'(-diff) : (W+1)'(diff);
         nneg = diff[W+1];
         dmag = (W+1)'(sq_mag_d) + ((W+1)'(sq_mag_d) << 1);
         dneg = sq_d[W-1];
      end
   end

   logic                 s5_vld_ff;
   logic [NUM_W-1:0]     s5_num_ff;
   logic [DEN_W-1:0]     s5_den_ff;
   logic [DV_SIDE_W-1:0] s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_num_ff  <= {nmag, {F{1'b0}}};
         s5_den_ff  <= dmag;
         s5_side_ff <= {sq_ctl.status, sq_x0, nneg ^ dneg};
      end
   end

   // quotient magnitude
   logic                 dv_vld;
   logic [NUM_W-1:0]     dv_quo;
   logic [DV_SIDE_W-1:0] dv_side;

   cac_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(DV_SIDE_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s5_vld_ff),
      .in_num   (s5_num_ff),
      .in_den   (s5_den_ff),
      .in_side  (s5_side_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // offset by origin and saturate
   status_type              dv_status;
   logic signed [W-1:0]     dv_x0;
   logic                    dv_neg;
   logic signed [SUM_W-1:0] q, sum, max_v, min_v, sat;
   logic signed [W-1:0]     arg_in;

   always_comb begin
      dv_status = status_type'(dv_side[DV_SIDE_W-1 -: STATUS_W]);
      dv_x0     = $signed(dv_side[W:1]);
      dv_neg    = dv_side[0];
      q         = SUM_W'(dv_quo);
      sum       = SUM_W'(dv_x0) + (dv_neg ? -q : q);
      max_v     = SUM_W'({1'b0, {(W-1){1'b1}}});
      min_v     = -max_v - SUM_W'(1);
      if (sum > max_v) begin
         sat = max_v;
      end else if (sum < min_v) begin
         sat = min_v;
      end else begin
         sat = sum;
      end
      arg_in = (dv_status == ST_FOUND) ? sat[W-1:0] : '0;
   end

   // output register with skid stage
   logic                out_vld_ff, skid_vld_ff;
   logic signed [W-1:0] out_arg_ff, skid_arg_ff;
   status_type          out_st_ff, skid_st_ff;
   logic                take;

   assign en   = !skid_vld_ff;
   assign take = en && dv_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_if.ready) begin
         out_vld_ff  <= skid_vld_ff || take;
         skid_vld_ff <= 1'b0;
      end else if (take) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_if.ready) begin
         out_arg_ff <= skid_vld_ff ? skid_arg_ff : arg_in;
         out_st_ff  <= skid_vld_ff ? skid_st_ff : dv_status;
      end else if (take) begin
         skid_arg_ff <= arg_in;
         skid_st_ff  <= dv_status;
      end
   end

   assign req_if.ready  = en;
   assign rsp_if.valid  = out_vld_ff;
   assign rsp_if.argmin = out_arg_ff;
   assign rsp_if.status = out_st_ff;

   // skid only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a transaction with no result waiting");

   // a held result keeps the skid occupied
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_if.ready) |=> skid_vld_ff)
      else $error("skid transaction lost while output stalled");

   // only a found minimiser carries a value
   a_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (out_st_ff != ST_FOUND)) |-> (rsp_if.argmin == '0))
      else $error("non-zero argmin with a failure status");

   // pipeline holds while the skid is full
   a_frozen_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> ($stable(dv_vld) && $stable(dv_quo)))
      else $error("pipeline moved while the skid was full");
endmodule

// File: design/cac_mul.sv
module cac_mul #(
   parameter int W = 48
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [W-1:0]   a,
   input  logic signed [W-1:0]   b,
   output logic signed [2*W-1:0] p
);
   localparam int H = (W + 1) / 2;

   logic [W-1:0]     mag_a, mag_b;
   logic [2*H-1:0]   ext_a, ext_b;
   logic [2*H-1:0]   p00_ff, p01_ff, p10_ff, p11_ff;
   logic             neg_ff;
   logic [4*H-1:0]   sum;
   logic [2*W-1:0]   mag_p;
   logic signed [2*W-1:0] p_ff;

   // magnitudes split into halves
   always_comb begin
      mag_a = a[W-1] ? W'(-a) : W'(a);
      mag_b = b[W-1] ? W'(-b) : W'(b);
      ext_a = (2*H)'(mag_a);
      ext_b = (2*H)'(mag_b);
   end

   // first stage: four partial products
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= (2*H)'(ext_a[H-1:0]) * (2*H)'(ext_b[H-1:0]);
         p01_ff <= (2*H)'(ext_a[H-1:0]) * (2*H)'(ext_b[2*H-1:H]);
         p10_ff <= (2*H)'(ext_a[2*H-1:H]) * (2*H)'(ext_b[H-1:0]);
         p11_ff <= (2*H)'(ext_a[2*H-1:H]) * (2*H)'(ext_b[2*H-1:H]);
         neg_ff <= a[W-1] ^ b[W-1];
      end
   end

   // second stage: combine and restore the sign
   always_comb begin
      sum = ((4*H)'(p11_ff) << (2*H)) + (((4*H)'(p01_ff) + (4*H)'(p10_ff)) << H)
            + (4*H)'(p00_ff);
      mag_p = sum[2*W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= neg_ff ? $signed(-mag_p) : $signed(mag_p);
      end
   end

   assign p = p_ff;
endmodule

// File: design/cac_sqrt.sv
module cac_sqrt #(
   parameter int IN_W   = 98,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [IN_W-1:0]     in_opnd,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_vld,
   output logic [IN_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int ROOT_W = IN_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int TRY_W  = REM_W + 2;

   logic              vld_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [IN_W-1:0]   opnd_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   // one root bit per stage
   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      logic              src_vld;
      logic [REM_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [IN_W-1:0]   src_opnd;
      logic [SIDE_W-1:0] src_side;
      logic [TRY_W-1:0]  shifted, trial, diff;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [IN_W-1:0]   opnd_in;

      if (g == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_opnd = in_opnd;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[g-1];
         assign src_rem  = rem_ff[g-1];
         assign src_root = root_ff[g-1];
         assign src_opnd = opnd_ff[g-1];
         assign src_side = side_ff[g-1];
      end

      always_comb begin
         shifted = {src_rem, src_opnd[IN_W-1:IN_W-2]};
         trial   = TRY_W'({src_root, 2'b01});
         ge      = shifted >= trial;
         diff    = shifted - trial;
         rem_in  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         root_in = {src_root[ROOT_W-2:0], ge};
         opnd_in = src_opnd << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            opnd_ff[g] <= opnd_in;
            side_ff[g] <= src_side;
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];
endmodule

// File: design/cac_div.sv
module cac_div #(
   parameter int NUM_W  = 73,
   parameter int DEN_W  = 49,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   logic              vld_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   // one quotient bit per stage, restoring
   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic              src_vld;
      logic [DEN_W-1:0]  src_rem;
      logic [NUM_W-1:0]  src_quo;
      logic [NUM_W-1:0]  src_num;
      logic [DEN_W-1:0]  src_den;
      logic [SIDE_W-1:0] src_side;
      logic [DEN_W:0]    shifted, diff;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  quo_in;
      logic [NUM_W-1:0]  num_in;

      if (g == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_rem  = '0;
         assign src_quo  = '0;
         assign src_num  = in_num;
         assign src_den  = in_den;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[g-1];
         assign src_rem  = rem_ff[g-1];
         assign src_quo  = quo_ff[g-1];
         assign src_num  = num_ff[g-1];
         assign src_den  = den_ff[g-1];
         assign src_side = side_ff[g-1];
      end

      always_comb begin
         shifted = {src_rem, src_num[NUM_W-1]};
         ge      = shifted >= {1'b0, src_den};
         diff    = shifted - {1'b0, src_den};
         rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in  = {src_quo[NUM_W-2:0], ge};
         num_in  = src_num << 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            quo_ff[g]  <= quo_in;
            num_ff[g]  <= num_in;
            den_ff[g]  <= src_den;
            side_ff[g] <= src_side;
         end
      end
   end

   assign out_vld  = vld_ff[NUM_W-1];
   assign out_quo  = quo_ff[NUM_W-1];
   assign out_side = side_ff[NUM_W-1];
endmodule
